[design/ipr_pkg.sv]
// Shared types, widths and register codes for the in-plane radial force unit.
package ipr_pkg;

   // Coordinate width of positions, centre, magnitude and force (signed Q16.16)
   localparam int COORD_W = 32;
   // Plane normal width (signed Q1.14)
   localparam int N_W = 16;
   // Normalized magnitude width after block scaling, and its signed form
   localparam int NORM_W = 30;
   localparam int V_W = NORM_W + 1;
   // Projection: dot product, projected vector, and the shift applied to v
   localparam int P1_W = V_W + N_W;
   localparam int D_W = 48;
   localparam int DN_W = D_W + N_W;
   // Signed u holds v * 2^28 - d * n for any 16-bit normal
   localparam int U_W = 63;
   localparam int PROJ_SHIFT = 28;
   // Sum of squares, root and remainder widths of the square-root pipe
   localparam int SQ_W = 2 * NORM_W;
   localparam int S_W = 62;
   localparam int ROOT_W = S_W / 2;
   localparam int REM_W = ROOT_W + 3;
   // Unit vector fraction bits, divider numerator and quotient widths
   localparam int E_FRAC = 30;
   localparam int NUM_W = NORM_W + E_FRAC + 1;
   localparam int Q_W = 31;
   // Final scaling: magnitude split in two halves
   localparam int HALF_W = 32;
   localparam int PROD_W = HALF_W + Q_W;
   localparam int RSUM_W = 2 * HALF_W + Q_W + 1;

   // Configuration register indexes
   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_CENTRE_X = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CENTRE_Y = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CENTRE_Z = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_NORMAL_X = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_NORMAL_Y = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_NORMAL_Z = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_FORCE_MAG = 3'd6;

   localparam logic signed [N_W-1:0] NORMAL_Z_RESET = 16'sd16384;

   typedef struct packed {
      logic signed [COORD_W-1:0] pos_x;
      logic signed [COORD_W-1:0] pos_y;
      logic signed [COORD_W-1:0] pos_z;
   } req_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] force_x;
      logic signed [COORD_W-1:0] force_y;
      logic signed [COORD_W-1:0] force_z;
      logic                      on_axis;
   } rsp_type;

   // Sideband that rides along the square-root pipe
   typedef struct packed {
      logic [2:0][NORM_W-1:0] wm;
      logic [2:0]             wneg;
      logic                   on_axis;
   } side_type;

   // Sideband that rides along the divider pipe
   typedef struct packed {
      logic [2:0] wneg;
      logic       on_axis;
   } div_side_type;

endpackage

[design/ipr_front.sv]
// Front pipe: offset, block scale, in-plane projection, block scale, sum of squares.
module ipr_front import ipr_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      adv,
   input  logic                      in_valid,
   input  req_type                   in_req,
   input  logic signed [COORD_W-1:0] centre [3],
   input  logic signed [N_W-1:0]     normal [3],
   output logic                      out_valid,
   output logic [S_W-1:0]            out_sum,
   output side_type                  out_side
);

   localparam int MAG1_W = COORD_W + 1;
   localparam int NW1 = (MAG1_W > NORM_W) ? MAG1_W : NORM_W;
   localparam int LZ1_W = $clog2(NW1);
   localparam int LZ2_W = $clog2(U_W);

   logic [10:0] valid_ff;

   // stage a: offset from centre
   logic [MAG1_W-1:0] a_mag_in [3], a_mag_ff [3];
   logic [2:0]        a_neg_in, a_neg_ff;
   // stage b: leading zero count
   logic [NW1-1:0]    b_mag_in [3], b_mag_ff [3];
   logic [LZ1_W-1:0]  b_lz_in, b_lz_ff;
   logic              b_zero_in, b_zero_ff;
   logic [2:0]        b_neg_ff;
   // stage c: normalized v
   logic signed [V_W-1:0] c_v_in [3], c_v_ff [3];
   logic              c_zero_ff;
   // stage d: v times n
   logic signed [P1_W-1:0] d_p_in [3], d_p_ff [3];
   logic signed [V_W-1:0]  d_v_ff [3];
   logic              d_zero_ff;
   // stage e: dot product
   logic signed [D_W-1:0] e_d_in, e_d_ff;
   logic signed [V_W-1:0] e_v_ff [3];
   logic              e_zero_ff;
   // stage f: d times n
   logic signed [DN_W-1:0] f_dn_in [3], f_dn_ff [3];
   logic signed [V_W-1:0]  f_v_ff [3];
   logic              f_zero_ff;
   // stage g: projected u
   logic [U_W-1:0]    g_mag_in [3], g_mag_ff [3];
   logic [2:0]        g_neg_in, g_neg_ff;
   logic              g_zero_ff;
   // stage h: leading zero count on u
   logic [LZ2_W-1:0]  h_lz_in, h_lz_ff;
   logic              h_zero_in, h_zero_ff;
   logic [U_W-1:0]    h_mag_ff [3];
   logic [2:0]        h_neg_ff;
   logic              h_zero1_ff;
   // stage i: normalized w
   logic [NORM_W-1:0] i_wm_in [3], i_wm_ff [3];
   logic [2:0]        i_neg_ff;
   logic              i_axis_in, i_axis_ff;
   // stage j: squares
   logic [SQ_W-1:0]   j_sq_in [3], j_sq_ff [3];
   logic [NORM_W-1:0] j_wm_ff [3];
   logic [2:0]        j_neg_ff;
   logic              j_axis_ff;
   // stage k: sum of squares
   logic [S_W-1:0]    k_sum_in, k_sum_ff;
   side_type          k_side_in, k_side_ff;

   logic signed [COORD_W-1:0] pos [3];
   assign pos[0] = in_req.pos_x;
   assign pos[1] = in_req.pos_y;
   assign pos[2] = in_req.pos_z;

   // compute offset magnitudes and signs
   always_comb begin
      logic signed [MAG1_W-1:0] diff;
      for (int i = 0; i < 3; i++) begin
         diff = MAG1_W'(pos[i]) - MAG1_W'(centre[i]);
         a_neg_in[i] = diff[MAG1_W-1];
         a_mag_in[i] = a_neg_in[i] ? MAG1_W'(MAG1_W'(0) - diff) : MAG1_W'(diff);
      end
   end

   // find the top set bit of the offsets
   always_comb begin
      logic [NW1-1:0]   orv;
      logic [LZ1_W-1:0] top;
      for (int i = 0; i < 3; i++) begin
         b_mag_in[i] = NW1'(a_mag_ff[i]);
      end
      orv = b_mag_in[0] | b_mag_in[1] | b_mag_in[2];
      top = '0;
      for (int b = 0; b < NW1; b++) begin
         if (orv[b]) begin
            top = LZ1_W'(b);
         end
      end
      b_lz_in = LZ1_W'(NW1 - 1) - top;
      b_zero_in = (orv == '0);
   end

   // normalize offsets and apply sign
   always_comb begin
      logic [NW1-1:0]    sh;
      logic [NORM_W-1:0] vm;
      for (int i = 0; i < 3; i++) begin
         sh = b_mag_ff[i] << b_lz_ff;
         vm = sh[NW1-1 -: NORM_W];
         c_v_in[i] = b_neg_ff[i] ? V_W'(V_W'(0) - V_W'(vm)) : V_W'(vm);
      end
   end

   // project out the normal component
   always_comb begin
      logic signed [U_W-1:0] u;
      for (int i = 0; i < 3; i++) begin
         d_p_in[i] = c_v_ff[i] * normal[i];
         f_dn_in[i] = e_d_ff * normal[i];
         u = (U_W'(f_v_ff[i]) <<< PROJ_SHIFT) - U_W'(f_dn_ff[i]);
         g_neg_in[i] = u[U_W-1];
         g_mag_in[i] = g_neg_in[i] ? U_W'(U_W'(0) - u) : U_W'(u);
      end
      e_d_in = D_W'(d_p_ff[0]) + D_W'(d_p_ff[1]) + D_W'(d_p_ff[2]);
   end

   // find the top set bit of the projection
   always_comb begin
      logic [U_W-1:0]   orv;
      logic [LZ2_W-1:0] top;
      orv = g_mag_ff[0] | g_mag_ff[1] | g_mag_ff[2];
      top = '0;
      for (int b = 0; b < U_W; b++) begin
         if (orv[b]) begin
            top = LZ2_W'(b);
         end
      end
      h_lz_in = LZ2_W'(U_W - 1) - top;
      h_zero_in = (orv == '0);
   end

   // normalize projection, square and sum
   always_comb begin
      logic [U_W-1:0] sh;
      for (int i = 0; i < 3; i++) begin
         sh = h_mag_ff[i] << h_lz_ff;
         i_wm_in[i] = sh[U_W-1 -: NORM_W];
         j_sq_in[i] = i_wm_ff[i] * i_wm_ff[i];
         k_side_in.wm[i] = j_wm_ff[i];
      end
      i_axis_in = h_zero1_ff | h_zero_ff;
      k_sum_in = S_W'(j_sq_ff[0]) + S_W'(j_sq_ff[1]) + S_W'(j_sq_ff[2]);
      k_side_in.wneg = j_neg_ff;
      k_side_in.on_axis = j_axis_ff;
   end

   // advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= {valid_ff[9:0], in_valid};
      end
   end

   // advance payload
   always_ff @(posedge clock) begin
      if (adv) begin
         a_mag_ff <= a_mag_in;
         a_neg_ff <= a_neg_in;
         b_mag_ff <= b_mag_in;
         b_lz_ff <= b_lz_in;
         b_zero_ff <= b_zero_in;
         b_neg_ff <= a_neg_ff;
         c_v_ff <= c_v_in;
         c_zero_ff <= b_zero_ff;
         d_p_ff <= d_p_in;
         d_v_ff <= c_v_ff;
         d_zero_ff <= c_zero_ff;
         e_d_ff <= e_d_in;
         e_v_ff <= d_v_ff;
         e_zero_ff <= d_zero_ff;
         f_dn_ff <= f_dn_in;
         f_v_ff <= e_v_ff;
         f_zero_ff <= e_zero_ff;
         g_mag_ff <= g_mag_in;
         g_neg_ff <= g_neg_in;
         g_zero_ff <= f_zero_ff;
         h_lz_ff <= h_lz_in;
         h_zero_ff <= h_zero_in;
         h_mag_ff <= g_mag_ff;
         h_neg_ff <= g_neg_ff;
         h_zero1_ff <= g_zero_ff;
         i_wm_ff <= i_wm_in;
         i_neg_ff <= h_neg_ff;
         i_axis_ff <= i_axis_in;
         j_sq_ff <= j_sq_in;
         j_wm_ff <= i_wm_ff;
         j_neg_ff <= i_neg_ff;
         j_axis_ff <= i_axis_ff;
         k_sum_ff <= k_sum_in;
         k_side_ff <= k_side_in;
      end
   end

   assign out_valid = valid_ff[10];
   assign out_sum = k_sum_ff;
   assign out_side = k_side_ff;

endmodule

[design/ipr_sqrt.sv]
// Pipelined integer square root, one root bit per stage.
module ipr_sqrt import ipr_pkg::*; #(
   parameter int SIDE_W = 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              adv,
   input  logic              in_valid,
   input  logic [S_W-1:0]    in_rad,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_valid,
   output logic [ROOT_W-1:0] out_root,
   output logic [SIDE_W-1:0] out_side
);

   logic [ROOT_W-1:0] root_ff [ROOT_W];
   logic [REM_W-1:0]  rem_ff  [ROOT_W];
   logic [S_W-1:0]    rad_ff  [ROOT_W];
   logic [SIDE_W-1:0] side_ff [ROOT_W];
   logic [ROOT_W-1:0] valid_ff;

   for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
      localparam int J = ROOT_W - 1 - k;
      logic [ROOT_W-1:0] root_prev, root_in;
      logic [REM_W-1:0]  rem_prev, rem_in;
      logic [S_W-1:0]    rad_prev;
      logic [SIDE_W-1:0] side_prev;
      logic              valid_prev;

      if (k == 0) begin : g_first
         assign root_prev = '0;
         assign rem_prev = '0;
         assign rad_prev = in_rad;
         assign side_prev = in_side;
         assign valid_prev = in_valid;
      end else begin : g_next
         assign root_prev = root_ff[k-1];
         assign rem_prev = rem_ff[k-1];
         assign rad_prev = rad_ff[k-1];
         assign side_prev = side_ff[k-1];
         assign valid_prev = valid_ff[k-1];
      end

      // bring in the next radicand pair and try the next root bit
      always_comb begin
         logic [REM_W-1:0] cur;
         logic [REM_W-1:0] trial;
         cur = {rem_prev[REM_W-3:0], rad_prev[2*J+1 -: 2]};
         trial = REM_W'({root_prev, 2'b01});
         if (cur >= trial) begin
            rem_in = cur - trial;
            root_in = {root_prev[ROOT_W-2:0], 1'b1};
         end else begin
            rem_in = cur;
            root_in = {root_prev[ROOT_W-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (adv) begin
            valid_ff[k] <= valid_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            root_ff[k] <= root_in;
            rem_ff[k] <= rem_in;
            rad_ff[k] <= rad_prev;
            side_ff[k] <= side_prev;
         end
      end
   end

   assign out_valid = valid_ff[ROOT_W-1];
   assign out_root = root_ff[ROOT_W-1];
   assign out_side = side_ff[ROOT_W-1];

endmodule

[design/ipr_div.sv]
// Pipelined restoring divider, three lanes sharing one divisor, one quotient bit per stage.
module ipr_div import ipr_pkg::*; #(
   parameter int SIDE_W = 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              adv,
   input  logic              in_valid,
   input  logic [NUM_W-1:0]  in_num [3],
   input  logic [ROOT_W-1:0] in_den,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_valid,
   output logic [Q_W-1:0]    out_quo [3],
   output logic [SIDE_W-1:0] out_side
);

   logic [ROOT_W-1:0] rem_ff  [Q_W][3];
   logic [Q_W-1:0]    quo_ff  [Q_W][3];
   logic [Q_W-1:0]    low_ff  [Q_W][3];
   logic [ROOT_W-1:0] den_ff  [Q_W];
   logic [SIDE_W-1:0] side_ff [Q_W];
   logic [Q_W-1:0]    valid_ff;

   for (genvar k = 0; k < Q_W; k++) begin : g_stage
      logic [ROOT_W-1:0] rem_prev [3];
      logic [Q_W-1:0]    quo_prev [3];
      logic [Q_W-1:0]    low_prev [3];
      logic [ROOT_W-1:0] rem_in [3];
      logic [Q_W-1:0]    quo_in [3];
      logic [ROOT_W-1:0] den_prev;
      logic [SIDE_W-1:0] side_prev;
      logic              valid_prev;

      if (k == 0) begin : g_first
         for (genvar l = 0; l < 3; l++) begin : g_lane
            assign rem_prev[l] = ROOT_W'(in_num[l][NUM_W-1:Q_W]);
            assign quo_prev[l] = '0;
            assign low_prev[l] = in_num[l][Q_W-1:0];
         end
         assign den_prev = in_den;
         assign side_prev = in_side;
         assign valid_prev = in_valid;
      end else begin : g_next
         assign rem_prev = rem_ff[k-1];
         assign quo_prev = quo_ff[k-1];
         assign low_prev = low_ff[k-1];
         assign den_prev = den_ff[k-1];
         assign side_prev = side_ff[k-1];
         assign valid_prev = valid_ff[k-1];
      end

      // shift in the next numerator bit and subtract where it fits
      always_comb begin
         logic [ROOT_W:0] cur;
         logic            ge;
         for (int l = 0; l < 3; l++) begin
            cur = {rem_prev[l], low_prev[l][Q_W-1-k]};
            ge = (cur >= {1'b0, den_prev});
            rem_in[l] = ge ? ROOT_W'(cur - {1'b0, den_prev}) : ROOT_W'(cur);
            quo_in[l] = {quo_prev[l][Q_W-2:0], ge};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (adv) begin
            valid_ff[k] <= valid_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[k] <= rem_in;
            quo_ff[k] <= quo_in;
            low_ff[k] <= low_prev;
            den_ff[k] <= den_prev;
            side_ff[k] <= side_prev;
         end
      end
   end

   assign out_valid = valid_ff[Q_W-1];
   assign out_quo = quo_ff[Q_W-1];
   assign out_side = side_ff[Q_W-1];

endmodule

[design/in_plane_radial_force_unit.sv]
// Pipeline: front, root, numerator, divide and scale stages from request accept to result
// valid, with one root bit and one quotient bit per stage.
// Throughput: one request per cycle; a stalled result holds the whole pipe.
// Reset: synchronous, clears all valid bits and the configuration registers
// (centre 0, normal (0,0,1), magnitude 0).
module in_plane_radial_force_unit import ipr_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  req_type              req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rsp_type              rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [COORD_W-1:0]   csr_data
);

   logic signed [COORD_W-1:0] centre_ff [3];
   logic signed [N_W-1:0]     normal_ff [3];
   logic signed [COORD_W-1:0] force_ff;

   logic adv;

   logic                 fr_valid;
   logic [S_W-1:0]       fr_sum;
   side_type             fr_side;

   logic                 sq_valid;
   logic [ROOT_W-1:0]    sq_root;
   logic [$bits(side_type)-1:0] sq_side_vec;
   side_type             sq_side;

   logic [NUM_W-1:0]     num_in [3], num_ff [3];
   logic [ROOT_W-1:0]    den_ff;
   div_side_type         dside_in, dside_ff;
   logic                 nvalid_ff;

   logic                 dv_valid;
   logic [Q_W-1:0]       dv_quo [3];
   logic [$bits(div_side_type)-1:0] dv_side_vec;
   div_side_type         dv_side;

   logic [PROD_W-1:0]    phi_in [3], phi_ff [3];
   logic [PROD_W-1:0]    plo_in [3], plo_ff [3];
   logic [2:0]           mneg_in, mneg_ff;
   logic                 maxis_ff;
   logic                 mvalid_ff;

   rsp_type              rsp_in, rsp_ff;
   logic                 rsp_valid_ff;

   // advance the pipe unless the held result is blocked
   assign adv = !rsp_valid_ff || rsp_ready;
   assign req_ready = adv;
   assign csr_ready = 1'b1;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         centre_ff[0] <= '0;
         centre_ff[1] <= '0;
         centre_ff[2] <= '0;
         normal_ff[0] <= '0;
         normal_ff[1] <= '0;
         normal_ff[2] <= NORMAL_Z_RESET;
         force_ff <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_CENTRE_X:  centre_ff[0] <= csr_data;
            CSR_CENTRE_Y:  centre_ff[1] <= csr_data;
            CSR_CENTRE_Z:  centre_ff[2] <= csr_data;
            CSR_NORMAL_X:  normal_ff[0] <= csr_data[N_W-1:0];
            CSR_NORMAL_Y:  normal_ff[1] <= csr_data[N_W-1:0];
            CSR_NORMAL_Z:  normal_ff[2] <= csr_data[N_W-1:0];
            CSR_FORCE_MAG: force_ff <= csr_data;
            default: begin
            end
         endcase
      end
   end

   ipr_front u_front (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (req_valid),
      .in_req    (req_data),
      .centre    (centre_ff),
      .normal    (normal_ff),
      .out_valid (fr_valid),
      .out_sum   (fr_sum),
      .out_side  (fr_side)
   );

   ipr_sqrt #(.SIDE_W($bits(side_type))) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (fr_valid),
      .in_rad    (fr_sum),
      .in_side   (fr_side),
      .out_valid (sq_valid),
      .out_root  (sq_root),
      .out_side  (sq_side_vec)
   );

   assign sq_side = sq_side_vec;

   // form rounded numerators w * 2^30 + len / 2
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         num_in[i] = (NUM_W'(sq_side.wm[i]) << E_FRAC) + NUM_W'(sq_root >> 1);
      end
      dside_in.wneg = sq_side.wneg;
      dside_in.on_axis = sq_side.on_axis;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         nvalid_ff <= 1'b0;
      end else if (adv) begin
         nvalid_ff <= sq_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         num_ff <= num_in;
         den_ff <= sq_root;
         dside_ff <= dside_in;
      end
   end

   ipr_div #(.SIDE_W($bits(div_side_type))) u_div (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (nvalid_ff),
      .in_num    (num_ff),
      .in_den    (den_ff),
      .in_side   (dside_ff),
      .out_valid (dv_valid),
      .out_quo   (dv_quo),
      .out_side  (dv_side_vec)
   );

   assign dv_side = dv_side_vec;

   // multiply magnitude halves by the unit vector components
   always_comb begin
      logic signed [2*HALF_W-1:0] f_ext;
      logic [2*HALF_W-1:0]        fm;
      f_ext = (2*HALF_W)'(force_ff);
      fm = force_ff[COORD_W-1] ? (2*HALF_W)'((2*HALF_W)'(0) - f_ext) : f_ext;
      for (int i = 0; i < 3; i++) begin
         phi_in[i] = fm[2*HALF_W-1:HALF_W] * dv_quo[i];
         plo_in[i] = fm[HALF_W-1:0] * dv_quo[i];
         mneg_in[i] = force_ff[COORD_W-1] ^ dv_side.wneg[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mvalid_ff <= 1'b0;
      end else if (adv) begin
         mvalid_ff <= dv_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         phi_ff <= phi_in;
         plo_ff <= plo_in;
         mneg_ff <= mneg_in;
         maxis_ff <= dv_side.on_axis;
      end
   end

   // round, saturate and sign the force components, zeroing them on axis
   always_comb begin
      logic [RSUM_W-1:0]  sum;
      logic [RSUM_W-1:0]  mag;
      logic [RSUM_W-1:0]  pos_max;
      logic [RSUM_W-1:0]  neg_lim;
      logic [COORD_W-1:0] comp [3];
      pos_max = RSUM_W'({1'b0, {(COORD_W-1){1'b1}}});
      neg_lim = pos_max + RSUM_W'(1);
      for (int i = 0; i < 3; i++) begin
         sum = (RSUM_W'(phi_ff[i]) << HALF_W) + RSUM_W'(plo_ff[i])
             + (RSUM_W'(1) << (E_FRAC - 1));
         mag = sum >> E_FRAC;
         if (mneg_ff[i]) begin
            if (mag > neg_lim) begin
               mag = neg_lim;
            end
            comp[i] = COORD_W'(RSUM_W'(0) - mag);
         end else begin
            if (mag > pos_max) begin
               mag = pos_max;
            end
            comp[i] = COORD_W'(mag);
         end
         if (maxis_ff) begin
            comp[i] = '0;
         end
      end
      rsp_in.force_x = comp[0];
      rsp_in.force_y = comp[1];
      rsp_in.force_z = comp[2];
      rsp_in.on_axis = maxis_ff;
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= mvalid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

endmodule

[tb/in_plane_radial_force_unit_checker.sv]
// Checker for the in-plane radial force unit: predicts forces and compares results.
`timescale 1ns / 1ps
module in_plane_radial_force_unit_checker import ipr_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_ready,
   input  req_type              req_data,
   input  logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  rsp_type              rsp_data,
   input  logic                 csr_valid,
   input  logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [COORD_W-1:0]   csr_data,
   output int                   fail_count,
   output int                   pending_count,
   output int                   axis_count,
   output int                   sat_count
);

   // Shadow copy of the configuration registers
   logic signed [63:0] centre [3];
   logic signed [63:0] normal [3];
   logic signed [63:0] magnitude;
   rsp_type            force_queue [$];

   // Magnitude bit position of the highest set bit
   function automatic int msb_of(logic [63:0] x);
      int n;
      n = 0;
      for (int i = 0; i < 64; i++)
         if (x[i]) n = i;
      return n;
   endfunction

   // Shift three magnitudes so the largest lies in [2^29, 2^30), keep signs
   function automatic void normalize3(input logic [63:0] mag [3], input bit neg [3],
                                      output logic signed [63:0] res [3]);
      int l;
      logic [63:0] m;
      l = msb_of(mag[0] | mag[1] | mag[2]);
      for (int i = 0; i < 3; i++) begin
         m = (l > 29) ? (mag[i] >> (l - 29)) : (mag[i] << (29 - l));
         res[i] = neg[i] ? -$signed(m) : $signed(m);
      end
   endfunction

   function automatic logic [63:0] int_sqrt(logic [63:0] s);
      logic [63:0] root, b;
      root = 0;
      b = 64'd1 << 62;
      while (b > s) b = b >> 2;
      while (b != 0) begin
         if (s >= root + b) begin
            s = s - (root + b);
            root = (root >> 1) + b;
         end else begin
            root = root >> 1;
         end
         b = b >> 2;
      end
      return root;
   endfunction

   // Scale the unit component by the magnitude, round, and saturate
   function automatic logic [COORD_W-1:0] scale_component(logic signed [63:0] f,
                                                        logic signed [63:0] e);
      logic [63:0] fm, em, hi, lo, r, pmax;
      bit neg;
      fm = (f < 0) ? -f : f;
      em = (e < 0) ? -e : e;
      neg = (f < 0) != (e < 0);
      hi = fm >> 32;
      lo = fm & 64'hFFFF_FFFF;
      r = hi * em * 4 + ((lo * em + (64'd1 << 29)) >> 30);
      pmax = 64'h7FFF_FFFF;
      if (!neg) begin
         if (r > pmax) r = pmax;
         return r[COORD_W-1:0];
      end
      if (r > pmax + 1) r = pmax + 1;
      r = -r;
      return r[COORD_W-1:0];
   endfunction

   function automatic rsp_type radial_force(req_type p);
      rsp_type res;
      logic [63:0] mag [3];
      bit neg [3];
      logic signed [63:0] v [3], u [3], w [3], pos [3];
      logic signed [63:0] dot, e;
      logic [63:0] s, len, wm, em;
      pos[0] = p.pos_x;
      pos[1] = p.pos_y;
      pos[2] = p.pos_z;
      res = '0;
      res.on_axis = 1'b1;
      for (int i = 0; i < 3; i++) begin
         neg[i] = pos[i] < centre[i];
         mag[i] = neg[i] ? centre[i] - pos[i] : pos[i] - centre[i];
      end
      if ((mag[0] | mag[1] | mag[2]) == 0) return res;
      normalize3(mag, neg, v);
      dot = v[0] * normal[0] + v[1] * normal[1] + v[2] * normal[2];
      for (int i = 0; i < 3; i++) begin
         u[i] = v[i] * 64'sd268435456 - dot * normal[i];
         neg[i] = u[i] < 0;
         mag[i] = neg[i] ? -u[i] : u[i];
      end
      if ((mag[0] | mag[1] | mag[2]) == 0) return res;
      normalize3(mag, neg, w);
      s = w[0] * w[0] + w[1] * w[1] + w[2] * w[2];
      len = int_sqrt(s);
      for (int i = 0; i < 3; i++) begin
         wm = (w[i] < 0) ? -w[i] : w[i];
         em = ((wm << 30) + (len >> 1)) / len;
         e = (w[i] < 0) ? -$signed(em) : $signed(em);
         case (i)
            0: res.force_x = scale_component(magnitude, e);
            1: res.force_y = scale_component(magnitude, e);
            default: res.force_z = scale_component(magnitude, e);
         endcase
      end
      res.on_axis = 1'b0;
      return res;
   endfunction

   task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
      $display("%0t: %s got %0h expected %0h", $realtime, field, got, want);
      fail_count++;
   endtask

   assign pending_count = force_queue.size();

   // Track configuration, queue predictions, and compare results
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         centre[0] <= 0; centre[1] <= 0; centre[2] <= 0;
         normal[0] <= 0; normal[1] <= 0; normal[2] <= NORMAL_Z_RESET;
         magnitude <= 0;
         force_queue.delete();
         fail_count = 0;
         axis_count = 0;
         sat_count = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_CENTRE_X: centre[0] <= $signed(csr_data);
               CSR_CENTRE_Y: centre[1] <= $signed(csr_data);
               CSR_CENTRE_Z: centre[2] <= $signed(csr_data);
               CSR_NORMAL_X: normal[0] <= $signed(csr_data[N_W-1:0]);
               CSR_NORMAL_Y: normal[1] <= $signed(csr_data[N_W-1:0]);
               CSR_NORMAL_Z: normal[2] <= $signed(csr_data[N_W-1:0]);
               CSR_FORCE_MAG: magnitude <= $signed(csr_data);
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            want = radial_force(req_data);
            force_queue.push_back(want);
            if (want.on_axis) axis_count++;
            if (want.force_x == 32'h7FFF_FFFF || want.force_x == 32'h8000_0000) sat_count++;
         end
         if (rsp_valid && rsp_ready) begin
            if (force_queue.size() == 0) begin
               report_mismatch("unexpected result", 64'(rsp_data.force_x), 64'(0));
            end else begin
               want = force_queue.pop_front();
               if (rsp_data.force_x !== want.force_x)
                  report_mismatch("force_x", 64'(rsp_data.force_x), 64'(want.force_x));
               if (rsp_data.force_y !== want.force_y)
                  report_mismatch("force_y", 64'(rsp_data.force_y), 64'(want.force_y));
               if (rsp_data.force_z !== want.force_z)
                  report_mismatch("force_z", 64'(rsp_data.force_z), 64'(want.force_z));
               if (rsp_data.on_axis !== want.on_axis)
                  report_mismatch("on_axis", 64'(rsp_data.on_axis), 64'(want.on_axis));
            end
         end
      end
   end

endmodule

[tb/in_plane_radial_force_unit_tb.sv]
// Top of the in-plane radial force unit testbench: stimulus, idling and verdict.
`timescale 1ns / 1ps
module in_plane_radial_force_unit_tb import ipr_pkg::*;;

   localparam int LATENCY    = 76;
   localparam int STALL_LIMIT = 20000;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   req_type              req_data;
   logic                 rsp_valid;
   logic                 rsp_ready;
   rsp_type              rsp_data;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [COORD_W-1:0]   csr_data;
   int                   fail_count;
   int                   pending_count;
   int                   axis_count;
   int                   sat_count;
   int                   request_count;
   int                   idle_cycles;
   bit                   hold_off;
   bit                   stall_pattern_on;

   in_plane_radial_force_unit i_dut (.*);

   in_plane_radial_force_unit_checker i_checker (.*);

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Stall the result side on its own pattern, with a long hold-off on demand
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off) begin
            rsp_ready <= 1'b0;
            repeat (300) @(negedge clock);
            hold_off = 1'b0;
         end else if (!stall_pattern_on) begin
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= ($urandom_range(0, 3) != 0);
         end
      end
   end

   // Watchdog: end the run after a long stretch with no handshake
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles > STALL_LIMIT) begin
            $display("in_plane_radial_force_unit: mismatch");
            $finish;
         end
      end
   end

   // Write one register, then drop valid and leave the channel idle
   task automatic write_register(logic [CSR_IDX_W-1:0] idx, logic [COORD_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   // Send one request and hold it until accepted; valid stays up for the next one
   task automatic send_position(logic [31:0] px, logic [31:0] py, logic [31:0] pz);
      req_valid <= 1'b1;
      req_data  <= '{pos_x: px, pos_y: py, pos_z: pz};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      request_count++;
      @(negedge clock);
   endtask

   // Drop the request, drain every expected result and let the pipe settle
   task automatic drain_all();
      req_valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (LATENCY + 4) @(negedge clock);
   endtask

   function automatic logic [31:0] random_coord();
      case ($urandom_range(0, 5))
         0: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
         1: return $urandom_range(0, 1000) - 500;
         2: return $urandom_range(0, 32'h3_FFFF) - 32'h2_0000;
         default: return $urandom;
      endcase
   endfunction

   task automatic apply_setting(logic [31:0] cx, logic [31:0] cy, logic [31:0] cz,
                                logic [15:0] nx, logic [15:0] ny, logic [15:0] nz,
                                logic [31:0] fm);
      write_register(CSR_CENTRE_X, cx);
      write_register(CSR_CENTRE_Y, cy);
      write_register(CSR_CENTRE_Z, cz);
      write_register(CSR_NORMAL_X, {{16{nx[15]}}, nx});
      write_register(CSR_NORMAL_Y, {{16{ny[15]}}, ny});
      write_register(CSR_NORMAL_Z, {{16{nz[15]}}, nz});
      write_register(CSR_FORCE_MAG, fm);
   endtask

   // Random burst phase for one configuration setting
   task automatic random_phase(int count);
      logic [31:0] base;
      int burst;
      burst = 0;
      for (int k = 0; k < count; k++) begin
         if (burst == 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clock);
            burst = $urandom_range(1, 20);
         end
         burst--;
         // Points with the centre's x and y hit the on-axis case when the normal lies along z
         if ($urandom_range(0, 15) == 0) begin
            base = $urandom_range(0, 1) ? 32'h0 : random_coord();
            send_position(i_checker.centre[0][31:0], i_checker.centre[1][31:0], base);
         end else begin
            send_position(random_coord(), random_coord(), random_coord());
         end
      end
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      hold_off = 1'b0;
      stall_pattern_on = 1'b0;
      request_count = 0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: magnitude at reset, then extremes with z-normal plane
      send_position(32'h0001_0000, 0, 0);
      drain_all();
      write_register(CSR_FORCE_MAG, 32'h0001_0000);
      send_position(0, 0, 0);
      send_position(0, 0, 32'h0005_0000);
      send_position(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
      send_position(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      send_position(32'hFFFF_FFFF, 32'h0000_0001, 0);
      send_position(32'h0003_0000, 32'h0004_0000, 32'h1234_5678);
      drain_all();
      apply_setting(32'h8000_0000, 32'h7FFF_FFFF, 0, 16'sd16384, 0, 0, 32'h7FFF_FFFF);
      send_position(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
      send_position(32'h8000_0000, 32'h7FFF_FFFF, 32'h1000);
      send_position(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
      send_position(0, 0, 0);
      send_position(32'h0000_1000, 32'h7FFF_0000, 32'h8000_0000);
      drain_all();
      apply_setting(0, 0, 0, 16'h8000, 16'h7FFF, 16'hC000, 32'h8000_0000);
      send_position(32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
      send_position(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_position(32'h8000_0000, 0, 32'hFFFF_0000);
      send_position(0, 0, 0);
      drain_all();
      apply_setting(0, 0, 0, 0, 0, 0, 32'hFFFF_FFFF);
      send_position(32'h0000_0001, 0, 0);
      send_position(32'hDEAD_BEEF, 32'h1234_5678, 32'h0BAD_F00D);
      drain_all();
      // A write beyond the register list must leave the setting untouched
      write_register(3'd7, 32'hFFFF_FFFF);
      send_position(32'h0000_0001, 0, 0);
      drain_all();

      // Random settings, with stalls on the result side
      stall_pattern_on = 1'b1;
      for (int ph = 0; ph < 6; ph++) begin
         apply_setting(random_coord(), random_coord(), random_coord(),
                       16'($urandom_range(0, 32768) - 16384),
                       16'($urandom_range(0, 32768) - 16384),
                       16'($urandom_range(0, 32768) - 16384),
                       (ph == 0) ? 32'h8000_0000 : (ph == 1) ? 32'h7FFF_FFFF : $urandom);
         if (ph == 2) begin
            // Long hold-off while requests keep coming so the pipe fills
            hold_off = 1'b1;
            random_phase(200);
         end else begin
            random_phase(95);
         end
         // Pause the sender until every expected result is back
         drain_all();
      end
      stall_pattern_on = 1'b0;
      random_phase(20);
      drain_all();

      $display("Run covered %0d requests over several settings; %0d on-axis, %0d saturated x.",
               request_count, axis_count, sat_count);
      if (fail_count == 0) begin
         $display("in_plane_radial_force_unit: match");
      end else begin
         $display("in_plane_radial_force_unit: mismatch");
      end
      $finish;
   end

endmodule
